// ===== hdl/gcht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcht_pkg
// Shared types and constants for the generation-checked handle table.
// ----------------------------------------------------------------------------
package gcht_pkg;

  localparam logic [31:0] HANDLE_BASE  = 32'hF000_0001;
  localparam logic [31:0] HANDLE_FLOOR = 32'hF000_0000;

  localparam int SLOT_W   = 8;   // slot field of a decoded handle
  localparam int GEN_W    = 16;  // generation stamp
  localparam int GRP_SIZE = 8;   // slots per group in the free-slot search
  localparam int GRP_IW   = 3;   // index width inside one group

  typedef enum logic [1:0] {
    OP_CREATE   = 2'd0,
    OP_LOOKUP   = 2'd1,
    OP_DELETE   = 2'd2,
    OP_FREE_ALL = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_HANDLE = 3'd1,
    ST_NO_ENTRY  = 3'd2,
    ST_FULL      = 3'd3,
    ST_STREAMS   = 3'd4
  } status_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;   // request taken: latch fields, read memories, group scan
    logic execute;   // finish request: update table, load result register
  } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/gcht_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcht_ctrl
// Request sequencer: capture cycle, execute cycle, result-valid tracking.
// ----------------------------------------------------------------------------
module gcht_ctrl
  import gcht_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output cmd_t      cmd
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // result register free, or its contents leave this edge
        if (!out_valid_r || !out_stall) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_hold_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && out_valid_r && out_stall) |=> (state_r == S_EXEC))
    else $error("execute left while result register still occupied");

  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_EXEC))
    else $error("captured request did not move to execute");

  a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> (out_valid_r && state_r == S_IDLE))
    else $error("executed request produced no result");

endmodule
`default_nettype wire

// ===== hdl/gcht_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcht_dp
// Handle table datapath: live bits, generation and usage memories, two-level
// free-slot search, counters and result register.
// ----------------------------------------------------------------------------
module gcht_dp
  import gcht_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_handle,
  input  wire logic [31:0] in_usage,
  input  wire logic        in_streams_valid,
  output logic [2:0]       out_status,
  output logic [31:0]      out_new_handle,
  output logic [5:0]       out_slot_index,
  output logic [31:0]      out_entry_usage,
  output logic [6:0]       out_live_entries,
  output logic [31:0]      out_created_total,
  output logic [31:0]      out_deleted_total,
  output logic [31:0]      out_refused_total
);

  localparam int AW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW   = $clog2(SLOT_COUNT + 1);
  localparam int NGRP = (SLOT_COUNT + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD  = NGRP * GRP_SIZE;

  // table state
  logic [SLOT_COUNT-1:0] live_r, live_nxt;
  logic [GEN_W-1:0]      gen_mem   [SLOT_COUNT];
  logic [31:0]           usage_mem [SLOT_COUNT];
  logic [GEN_W-1:0]      next_gen_r, next_gen_nxt;
  logic [CW-1:0]         live_cnt_r, live_cnt_nxt;
  logic [31:0]           created_r, created_nxt;
  logic [31:0]           deleted_r, deleted_nxt;
  logic [31:0]           refused_r, refused_nxt;

  // captured request
  op_t              op_r;
  logic [31:0]      usage_r;
  logic             streams_r;
  logic             above_floor_r;
  logic [SLOT_W-1:0] slot_r;
  logic [GEN_W-1:0] hgen_r;
  logic [GEN_W-1:0] gen_rd_r;
  logic [31:0]      usage_rd_r;

  // free-slot search, group stage
  logic [PAD-1:0]    free_pad;
  logic [NGRP-1:0]   grp_any, grp_any_r;
  logic [GRP_IW-1:0] grp_loc   [NGRP];
  logic [GRP_IW-1:0] grp_loc_r [NGRP];
  logic [GW-1:0]     sel_grp;
  logic              any_free;
  logic [SLOT_W-1:0] free_idx;
  logic [AW-1:0]     wr_addr;

  // handle decode
  logic [31:0] raw_in;
  logic [AW-1:0] rd_addr;

  // execute results
  logic              slot_in_range;
  logic              hit;
  logic              mem_we;
  status_t           status;
  logic [31:0]       new_handle;
  logic [SLOT_W-1:0] slot_o;
  logic [31:0]       usage_o;
  logic [GEN_W-1:0]  gen_inc;
  logic [31:0]       cnt_ext;

  assign raw_in  = in_handle - HANDLE_BASE;
  assign rd_addr = raw_in[AW-1:0];

  // per-group lowest free slot
  always_comb begin
    free_pad = '0;
    for (int i = 0; i < SLOT_COUNT; i++) free_pad[i] = ~live_r[i];
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = |free_pad[g*GRP_SIZE +: GRP_SIZE];
      grp_loc[g] = '0;
      for (int j = GRP_SIZE - 1; j >= 0; j--) begin
        if (free_pad[g*GRP_SIZE + j]) grp_loc[g] = GRP_IW'(j);
      end
    end
  end

  // lowest group with a free slot
  always_comb begin
    any_free = |grp_any_r;
    sel_grp  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) sel_grp = GW'(g);
    end
    free_idx = SLOT_W'({sel_grp, grp_loc_r[sel_grp]});
  end

  assign wr_addr       = free_idx[AW-1:0];
  assign slot_in_range = ({1'b0, slot_r} < (SLOT_W + 1)'(SLOT_COUNT));
  assign hit           = above_floor_r && slot_in_range && live_r[slot_r[AW-1:0]]
                         && (gen_rd_r == hgen_r);
  assign gen_inc       = next_gen_r + GEN_W'(1);

  always_comb begin
    live_nxt     = live_r;
    next_gen_nxt = next_gen_r;
    live_cnt_nxt = live_cnt_r;
    created_nxt  = created_r;
    deleted_nxt  = deleted_r;
    refused_nxt  = refused_r;
    mem_we       = 1'b0;
    status       = ST_OK;
    new_handle   = '0;
    slot_o       = '0;
    usage_o      = '0;
    case (op_r)
      OP_CREATE: begin
        if (!streams_r) begin
          status      = ST_STREAMS;
          refused_nxt = refused_r + 32'd1;
        end else if (!any_free) begin
          status      = ST_FULL;
          refused_nxt = refused_r + 32'd1;
        end else begin
          mem_we            = 1'b1;
          live_nxt[wr_addr] = 1'b1;
          next_gen_nxt      = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
          live_cnt_nxt      = live_cnt_r + CW'(1);
          created_nxt       = created_r + 32'd1;
          new_handle        = HANDLE_BASE + {8'd0, next_gen_r, 8'd0} + 32'(free_idx);
          slot_o            = free_idx;
        end
      end
      OP_LOOKUP, OP_DELETE: begin
        if (!above_floor_r) begin
          status      = ST_NOT_HANDLE;
          refused_nxt = refused_r + 32'd1;
        end else if (!hit) begin
          status      = ST_NO_ENTRY;
          refused_nxt = refused_r + 32'd1;
        end else begin
          slot_o  = slot_r;
          usage_o = usage_rd_r;
          if (op_r == OP_DELETE) begin
            live_nxt[slot_r[AW-1:0]] = 1'b0;
            live_cnt_nxt             = live_cnt_r - CW'(1);
            deleted_nxt              = deleted_r + 32'd1;
          end
        end
      end
      OP_FREE_ALL: begin
        live_nxt     = '0;
        live_cnt_nxt = '0;
      end
      default: ;
    endcase
  end

  assign cnt_ext = 32'(live_cnt_nxt);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r     <= '0;
      next_gen_r <= GEN_W'(1);
      live_cnt_r <= '0;
      created_r  <= '0;
      deleted_r  <= '0;
      refused_r  <= '0;
    end else if (cmd.execute) begin
      live_r     <= live_nxt;
      next_gen_r <= next_gen_nxt;
      live_cnt_r <= live_cnt_nxt;
      created_r  <= created_nxt;
      deleted_r  <= deleted_nxt;
      refused_r  <= refused_nxt;
    end
  end

  // capture stage: fields, memory reads, group scan
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r          <= op_t'(in_operation);
      usage_r       <= in_usage;
      streams_r     <= in_streams_valid;
      above_floor_r <= (in_handle > HANDLE_FLOOR);
      slot_r        <= raw_in[SLOT_W-1:0];
      hgen_r        <= raw_in[SLOT_W +: GEN_W];
      gen_rd_r      <= gen_mem[rd_addr];
      usage_rd_r    <= usage_mem[rd_addr];
      grp_any_r     <= grp_any;
      grp_loc_r     <= grp_loc;
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (cmd.execute && mem_we) begin
      gen_mem[wr_addr]   <= next_gen_r;
      usage_mem[wr_addr] <= usage_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status        <= status;
      out_new_handle    <= new_handle;
      out_slot_index    <= slot_o[5:0];
      out_entry_usage   <= usage_o;
      out_live_entries  <= cnt_ext[6:0];
      out_created_total <= created_nxt;
      out_deleted_total <= deleted_nxt;
      out_refused_total <= refused_nxt;
    end
  end

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(live_r) == int'(live_cnt_r))
    else $error("live count out of step with live bits");

  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_gen_r != '0)
    else $error("generation counter reached zero");

  a_create_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && mem_we) |=> live_r[$past(wr_addr)])
    else $error("created slot not marked live");

endmodule
`default_nettype wire

// ===== hdl/generation_checked_handle_table_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// generation_checked_handle_table_unit
// Slot table issuing generation-checked 32-bit handles.
// ----------------------------------------------------------------------------
// Use:
//   in_*  request channel: operation (create, lookup, delete, free all),
//         handle, usage word and the stream check bit. Taken when in_valid
//         is high and in_stall is low.
//   out_* result channel: status, issued handle, slot, stored usage word,
//         live slot count and the three wrapping request counters.
//   Every request yields exactly one result.
// Timing:
//   A request is captured (generation/usage memory read and per-group
//   free-slot scan registered), then finished in the execute step
//   (generation compare, table update, result register load), which waits
//   while the result register is held. No new request is taken until the
//   current one is finished; the compare needs the registered memory read.
// Stall:
//   The result register holds while out_stall is high. One more request
//   may be taken meanwhile; it waits in the execute step until the register
//   drains.
// Reset:
//   Synchronous, active low. All slots free, generation counter 1, counters
//   zero. Memories need no clearing: only live slots are read back.
// ----------------------------------------------------------------------------
module generation_checked_handle_table_unit
  import gcht_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_handle,
  input  wire logic [31:0] in_usage,
  input  wire logic        in_streams_valid,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_new_handle,
  output logic [5:0]       out_slot_index,
  output logic [31:0]      out_entry_usage,
  output logic [6:0]       out_live_entries,
  output logic [31:0]      out_created_total,
  output logic [31:0]      out_deleted_total,
  output logic [31:0]      out_refused_total
);

  cmd_t cmd;

  // sequencer: IDLE takes a request, EXEC finishes it when the result
  // register can accept
  gcht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // table storage, handle decode, free-slot search and counters
  gcht_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_operation),
    .in_handle         (in_handle),
    .in_usage          (in_usage),
    .in_streams_valid  (in_streams_valid),
    .out_status        (out_status),
    .out_new_handle    (out_new_handle),
    .out_slot_index    (out_slot_index),
    .out_entry_usage   (out_entry_usage),
    .out_live_entries  (out_live_entries),
    .out_created_total (out_created_total),
    .out_deleted_total (out_deleted_total),
    .out_refused_total (out_refused_total)
  );

endmodule
`default_nettype wire
